/* hdl/time_message_serial_transmitter_top_assert.svh */
// assertion macros for the time message transmitter
`ifndef TIME_MESSAGE_SERIAL_TRANSMITTER_TOP_ASSERT_SVH
`define TIME_MESSAGE_SERIAL_TRANSMITTER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TMST_ASSERT_NOW(name, clk_sig, rst_n_sig, ante, cons, msg) \
	name: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) \
		(ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define TMST_ASSERT_NEXT(name, clk_sig, rst_n_sig, ante, cons, msg) \
	name: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) \
		(ante) |=> (cons)) else $error(msg);

`endif

/* hdl/tmst_pkg.sv */
`default_nettype none

package tmst_pkg;

	// command codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SEND = 1'b1;

	// frame and message constants
	localparam int unsigned MSG_LEN   = 6;
	localparam int unsigned DATA_BITS = 8;
	localparam int unsigned MSG_BITS  = MSG_LEN * DATA_BITS;

	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_COLON = 8'd58;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;

	// one input transaction
	typedef struct packed {
		logic       opcode;
		logic [3:0] digit_hour_tens;
		logic [3:0] digit_hour_units;
		logic [3:0] digit_minute_tens;
		logic [3:0] digit_minute_units;
	} cmd_t;

	// one result transaction
	typedef struct packed {
		logic line_level;
		logic idle;
	} res_t;

	// digit to character, no range check
	function automatic logic [7:0] to_char(input logic [3:0] digit);
		return {4'd0, digit} + CHAR_ZERO;
	endfunction

endpackage

`default_nettype wire

/* hdl/tmst_in_stage.sv */
`default_nettype none

module tmst_in_stage
	import tmst_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	input  wire logic adv,
	output logic      valid_s1,
	output cmd_t      cmd_s1
);

	logic load;

	// hold a transaction while the next stage cannot take it
	assign cmd_stall = valid_s1 && !adv;
	assign load      = cmd_valid && !cmd_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= cmd_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s1 <= cmd;
		end
	end

endmodule

`default_nettype wire

/* hdl/tmst_frame_engine.sv */
`default_nettype none

module tmst_frame_engine
	import tmst_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic fire,
	input  wire cmd_t cmd_s1,
	output res_t      res_next
);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_START = 2'd1;
	localparam logic [1:0] PH_DATA  = 2'd2;
	localparam logic [1:0] PH_STOP  = 2'd3;

	localparam logic [3:0] BITS_LAST  = 4'(DATA_BITS);
	localparam logic [2:0] CHAR_LAST  = 3'(MSG_LEN - 1);

	logic [1:0]          phase_q,    phase_n;
	logic [2:0]          char_idx_q, char_idx_n;
	logic [3:0]          bits_q,     bits_n;
	logic [MSG_BITS-1:0] msg_q,      msg_n;
	logic                line_q,     line_n;

	// next state for one transaction
	always_comb begin
		phase_n    = phase_q;
		char_idx_n = char_idx_q;
		bits_n     = bits_q;
		msg_n      = msg_q;
		line_n     = line_q;
		if (cmd_s1.opcode == OP_SEND) begin
			// message is shifted out from bit 0 upward, carriage return first
			msg_n      = {to_char(cmd_s1.digit_minute_units),
				to_char(cmd_s1.digit_minute_tens), CHAR_COLON,
				to_char(cmd_s1.digit_hour_units),
				to_char(cmd_s1.digit_hour_tens), CHAR_CR};
			char_idx_n = '0;
			bits_n     = '0;
			phase_n    = PH_START;
		end else begin
			unique case (phase_q)
				PH_START: begin
					line_n  = 1'b0;
					phase_n = PH_DATA;
				end
				PH_DATA: begin
					line_n = msg_q[0];
					msg_n  = msg_q >> 1;
					bits_n = bits_q + 4'd1;
					if (bits_n >= BITS_LAST) begin
						phase_n = PH_STOP;
					end
				end
				PH_STOP: begin
					line_n = 1'b1;
					bits_n = '0;
					if (char_idx_q < CHAR_LAST) begin
						char_idx_n = char_idx_q + 3'd1;
						phase_n    = PH_START;
					end else begin
						char_idx_n = '0;
						phase_n    = PH_IDLE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign res_next.line_level = line_n;
	assign res_next.idle       = (phase_n == PH_IDLE);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			char_idx_q <= '0;
			bits_q     <= '0;
			line_q     <= 1'b1;
		end else if (fire) begin
			phase_q    <= phase_n;
			char_idx_q <= char_idx_n;
			bits_q     <= bits_n;
			line_q     <= line_n;
		end
	end

	// message shift register
	always_ff @(posedge clk) begin
		if (fire) begin
			msg_q <= msg_n;
		end
	end

endmodule

`default_nettype wire

/* hdl/tmst_out_stage.sv */
`default_nettype none

module tmst_out_stage
	import tmst_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic valid_s1,
	input  wire res_t res_next,
	output logic      adv,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res_q
);

	// room when empty or the held result leaves this cycle
	assign adv = !res_valid || !res_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= valid_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_q <= res_next;
		end
	end

endmodule

`default_nettype wire

/* hdl/time_message_serial_transmitter_top.sv */
// Serial transmitter for a six-character time message ("\r", h, h, ':', m, m) in 8N1
// frames, LSB first. A send transaction loads four digits (48 is added to each) and
// restarts the frame sequence; each tick transaction drives the next line level:
// start bit, eight data bits, stop bit. Every command gives exactly one result with
// the line level after it and an idle flag; the line rests high when idle. One
// transaction is accepted every clock while cmd_stall is low; its result passes through
// the input register and then the result register, with the state update between
// them. A stalled result holds the input only once both registers are full.
`default_nettype none
`include "time_message_serial_transmitter_top_assert.svh"

module time_message_serial_transmitter_top
	import tmst_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_stall,
	input  wire logic       opcode,
	input  wire logic [3:0] digit_hour_tens,
	input  wire logic [3:0] digit_hour_units,
	input  wire logic [3:0] digit_minute_tens,
	input  wire logic [3:0] digit_minute_units,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic            line_level,
	output logic            idle
);

	cmd_t cmd;
	cmd_t cmd_s1;
	logic valid_s1;
	logic adv;
	res_t res_next;
	res_t res_q;

	// gather the payload
	assign cmd.opcode             = opcode;
	assign cmd.digit_hour_tens    = digit_hour_tens;
	assign cmd.digit_hour_units   = digit_hour_units;
	assign cmd.digit_minute_tens  = digit_minute_tens;
	assign cmd.digit_minute_units = digit_minute_units;

	tmst_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.cmd_s1    (cmd_s1)
	);

	tmst_frame_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (valid_s1 && adv),
		.cmd_s1   (cmd_s1),
		.res_next (res_next)
	);

	tmst_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res_next  (res_next),
		.adv       (adv),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_q     (res_q)
	);

	assign line_level = res_q.line_level;
	assign idle       = res_q.idle;

	// checks
	`TMST_ASSERT_NOW(a_idle_line_high, clk, arst_n, res_valid && idle, line_level,
		"idle result with line low")
	`TMST_ASSERT_NOW(a_stall_needs_item, clk, arst_n, cmd_stall, valid_s1,
		"input stalled with empty stage")
	`TMST_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !adv,
		valid_s1 && $stable(cmd_s1), "held transaction lost or changed")

endmodule

`default_nettype wire

/* dv/tb_time_message_serial_transmitter_top.sv */
`timescale 1ns / 100ps

module tb_time_message_serial_transmitter_top;
	import tmst_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 600;
	localparam int ITEMS_PER_MIX = 150;
	localparam int HOLD_CYCLES   = 60;
	localparam int DRAIN_CYCLES  = 10;
	localparam int FRAME_TICKS   = DATA_BITS + 2;
	localparam bit TYPED = 1'b1;
	localparam bit FREE  = 1'b0;

	// transmitter phase as the predictor tracks it
	typedef enum logic [1:0] {
		TX_IDLE  = 2'd0,
		TX_START = 2'd1,
		TX_DATA  = 2'd2,
		TX_STOP  = 2'd3
	} tx_phase_e;

	// one directed row: command, whether the result is written out, the result
	typedef struct packed {
		cmd_t cmd;
		logic typed;
		res_t want;
	} vector_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       opcode = OP_TICK;
	logic [3:0] digit_hour_tens = 4'd0;
	logic [3:0] digit_hour_units = 4'd0;
	logic [3:0] digit_minute_tens = 4'd0;
	logic [3:0] digit_minute_units = 4'd0;
	logic       res_stall = 1'b0;
	wire        cmd_stall;
	wire        res_valid;
	wire        line_level;
	wire        idle;

	// predictor state
	tx_phase_e  tx_phase = TX_IDLE;
	int         cur_char = 0;
	int         bit_count = 0;
	logic [7:0] msg_chars [MSG_LEN];
	logic       line_reg = 1'b1;

	res_t pending_levels [$];
	int   mismatch_count = 0;
	int   sender_gap_pct = 0;
	int   receiver_stall_pct = 0;
	int   hold_requests = 0;
	int   cycle_count = 0;

	// directed sequence: idle ticks, a first message, restart mid-character,
	// and digits above nine
	vector_t dir_rows [24] = '{
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  TYPED, 1'b1, 1'b1},
		{OP_TICK, 4'd15, 4'd15, 4'd15, 4'd15, TYPED, 1'b1, 1'b1},
		{OP_SEND, 4'd0,  4'd0,  4'd0,  4'd0,  TYPED, 1'b1, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  TYPED, 1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  FREE,  1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  FREE,  1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  FREE,  1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  FREE,  1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  FREE,  1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  FREE,  1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  FREE,  1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  FREE,  1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  TYPED, 1'b1, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  TYPED, 1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  FREE,  1'b0, 1'b0},
		{OP_SEND, 4'd9,  4'd9,  4'd9,  4'd9,  FREE,  1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  TYPED, 1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  FREE,  1'b0, 1'b0},
		{OP_SEND, 4'd15, 4'd15, 4'd15, 4'd15, FREE,  1'b0, 1'b0},
		{OP_TICK, 4'd5,  4'd10, 4'd3,  4'd12, TYPED, 1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  FREE,  1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  FREE,  1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  FREE,  1'b0, 1'b0},
		{OP_TICK, 4'd0,  4'd0,  4'd0,  4'd0,  FREE,  1'b0, 1'b0}
	};

	time_message_serial_transmitter_top u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd_valid          (cmd_valid),
		.cmd_stall          (cmd_stall),
		.opcode             (opcode),
		.digit_hour_tens    (digit_hour_tens),
		.digit_hour_units   (digit_hour_units),
		.digit_minute_tens  (digit_minute_tens),
		.digit_minute_units (digit_minute_units),
		.res_valid          (res_valid),
		.res_stall          (res_stall),
		.line_level         (line_level),
		.idle               (idle)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// line level and idle flag after one command
	function automatic res_t advance_transmitter(cmd_t c);
		res_t r;
		if (c.opcode == OP_SEND) begin
			msg_chars[0] = CHAR_CR;
			msg_chars[1] = {4'd0, c.digit_hour_tens} + CHAR_ZERO;
			msg_chars[2] = {4'd0, c.digit_hour_units} + CHAR_ZERO;
			msg_chars[3] = CHAR_COLON;
			msg_chars[4] = {4'd0, c.digit_minute_tens} + CHAR_ZERO;
			msg_chars[5] = {4'd0, c.digit_minute_units} + CHAR_ZERO;
			cur_char = 0;
			bit_count = 0;
			tx_phase = TX_START;
		end else begin
			case (tx_phase)
				TX_START: begin
					line_reg = 1'b0;
					tx_phase = TX_DATA;
				end
				TX_DATA: begin
					line_reg = msg_chars[cur_char][0];
					msg_chars[cur_char] = msg_chars[cur_char] >> 1;
					bit_count++;
					if (bit_count >= DATA_BITS)
						tx_phase = TX_STOP;
				end
				TX_STOP: begin
					line_reg = 1'b1;
					bit_count = 0;
					if (cur_char + 1 < MSG_LEN) begin
						cur_char++;
						tx_phase = TX_START;
					end else begin
						cur_char = 0;
						tx_phase = TX_IDLE;
					end
				end
				default: ;
			endcase
		end
		r.line_level = line_reg;
		r.idle = (tx_phase == TX_IDLE);
		return r;
	endfunction

	// random digit, mostly decimal, sometimes the full nibble
	function automatic logic [3:0] pick_digit();
		if ($urandom_range(9) == 0)
			return 4'($urandom_range(15));
		return 4'($urandom_range(9));
	endfunction

	// offer one command after a random gap and record what it should give
	task automatic send_command(cmd_t c, logic typed, res_t want);
		res_t predicted;
		while ($urandom_range(99) < sender_gap_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid          <= 1'b1;
		opcode             <= c.opcode;
		digit_hour_tens    <= c.digit_hour_tens;
		digit_hour_units   <= c.digit_hour_units;
		digit_minute_tens  <= c.digit_minute_tens;
		digit_minute_units <= c.digit_minute_units;
		do @(posedge clk); while (cmd_stall);
		predicted = advance_transmitter(c);
		pending_levels.push_back(typed ? want : predicted);
	endtask

	// drop valid and wait until every expected result has come back
	task automatic wait_for_drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending_levels.size() != 0)
			@(posedge clk);
	endtask

	// stimulus
	initial begin
		cmd_t item;
		int   ticks_left;
		bit   send_now;
		ticks_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r])
			send_command(dir_rows[r].cmd, dir_rows[r].typed, dir_rows[r].want);
		wait_for_drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// idling mix per quarter
			if (i % ITEMS_PER_MIX == 0) begin
				case (i / ITEMS_PER_MIX)
					0: begin sender_gap_pct = 0;  receiver_stall_pct <= 0;  end
					1: begin sender_gap_pct = 81; receiver_stall_pct <= 0;  end
					2: begin sender_gap_pct = 0;  receiver_stall_pct <= 81; end
					default: begin sender_gap_pct = 10; receiver_stall_pct <= 10; end
				endcase
			end
			// long receiver hold-off while commands keep coming
			if (i == ITEMS_PER_MIX / 2)
				hold_requests <= hold_requests + 1;
			// full messages with random digits, some restarts and idle ticks
			if (ticks_left == 0)
				send_now = ($urandom_range(3) != 0);
			else
				send_now = ($urandom_range(49) == 0);
			item.opcode             = send_now ? OP_SEND : OP_TICK;
			item.digit_hour_tens    = pick_digit();
			item.digit_hour_units   = pick_digit();
			item.digit_minute_tens  = pick_digit();
			item.digit_minute_units = pick_digit();
			if (send_now)
				ticks_left = MSG_LEN * FRAME_TICKS;
			else if (ticks_left > 0)
				ticks_left--;
			send_command(item, FREE, '0);
			// sender pause until the block has drained
			if (i == 2 * ITEMS_PER_MIX - 1)
				wait_for_drain();
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// result check and receiver stall
	always @(posedge clk) begin
		res_t exp_res;
		static int hold_left = 0;
		static int hold_seen = 0;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (pending_levels.size() == 0) begin
					$error("result transaction with nothing expected");
					mismatch_count++;
				end else begin
					exp_res = pending_levels.pop_front();
					if (line_level !== exp_res.line_level) begin
						$error("line_level: expected %0b, got %0b",
							exp_res.line_level, line_level);
						mismatch_count++;
					end
					if (idle !== exp_res.idle) begin
						$error("idle: expected %0b, got %0b", exp_res.idle, idle);
						mismatch_count++;
					end
				end
			end
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else
				res_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule
